[hdl/skam_pkg.sv]
// Shared constants, codes and types for the sorted-key adjacency matrix.
// Used by skam_cell and sorted_key_adjacency_matrix.
`default_nettype none
package skam_pkg;
    localparam int NODES = 16;
    localparam int KEY_W = 16;
    localparam int IDX_W = $clog2(NODES);
    localparam int CNT_W = $clog2(NODES + 1);

    localparam logic [2:0] FN_ADD_NODE = 3'd0;
    localparam logic [2:0] FN_DEL_NODE = 3'd1;
    localparam logic [2:0] FN_ADD_EDGE = 3'd2;
    localparam logic [2:0] FN_DEL_EDGE = 3'd3;
    localparam logic [2:0] FN_READ     = 3'd4;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_FULL   = 3'd1;
    localparam logic [2:0] ST_EMPTY  = 3'd2;
    localparam logic [2:0] ST_NOKEY  = 3'd3;
    localparam logic [2:0] ST_EXISTS = 3'd4;
    localparam logic [2:0] ST_ABSENT = 3'd5;
    localparam logic [2:0] ST_UNUSED = 3'd6;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INS,
        OP_DEL,
        OP_SET,
        OP_CLR
    } cell_op_t;

    // pos: slot being inserted/removed, or row for edge ops; col: edge column
    typedef struct packed {
        cell_op_t         op;
        logic [IDX_W-1:0] pos;
        logic [IDX_W-1:0] col;
    } cell_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] lo;
        logic [CNT_W-1:0] hi;  // one past the last candidate slot
        logic             fnd;
        logic [IDX_W-1:0] idx;
    } srch_t;
endpackage
`default_nettype wire

[hdl/sorted_key_adjacency_matrix.sv]
// Directed graph of up to 16 nodes held in a chain of slot cells, keys sorted
// ascending, edges as an adjacency bit matrix. One item at a time: a transfer
// in, one search step per cycle for both keys (done at once when the graph is
// empty, at most five steps with 16 nodes), an update state in which every
// cell shifts and adjusts its row in parallel, and a result stage that loads
// the result register. A stalled receiver can hold the result stage until the
// previous result is taken. The next item is taken while the previous result
// waits. No clearing pass. Depends on skam_pkg and skam_cell.
`default_nettype none
module sorted_key_adjacency_matrix (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         in_valid,
    output logic                        in_ready,
    input  wire [2:0]                   func,
    input  wire [skam_pkg::KEY_W-1:0]   key_a,
    input  wire [skam_pkg::KEY_W-1:0]   key_b,
    input  wire [skam_pkg::IDX_W-1:0]   slot_index,
    output logic                        out_valid,
    input  wire                         out_ready,
    output logic [2:0]                  status,
    output logic [skam_pkg::CNT_W-1:0]  node_count,
    output logic [skam_pkg::KEY_W-1:0]  read_key,
    output logic [skam_pkg::NODES-1:0]  read_row
);
    import skam_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_APPLY  = 4'b0100,
        S_OUT    = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]       func_reg;
    logic [KEY_W-1:0] ka_reg, kb_reg;
    logic [IDX_W-1:0] slot_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    srch_t            sa_reg, sa_next, sb_reg, sb_next;

    logic [2:0]       res_st_reg, res_st_next;
    logic [KEY_W-1:0] res_key_reg, res_key_next;
    logic [NODES-1:0] res_row_reg, res_row_next;

    logic             out_valid_reg, out_valid_next;
    logic [2:0]       status_reg;
    logic [CNT_W-1:0] node_count_reg;
    logic [KEY_W-1:0] read_key_reg;
    logic [NODES-1:0] read_row_reg;

    cell_cmd_t        cmd;
    logic [KEY_W-1:0] key_w [NODES];
    logic [NODES-1:0] row_w [NODES];
    logic [NODES-1:0] eq_a, lt_a, eq_b, lt_b;
    logic [NODES-1:0] occ;
    logic [IDX_W-1:0] ins_pos;
    logic             pos_hit;
    logic             in_xfer, out_load;

    genvar gi;
    generate
        for (gi = 0; gi < NODES; gi++)
        begin : g_cell
            skam_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .idx       (IDX_W'(gi)),
                .key_a     (ka_reg),
                .key_b     (kb_reg),
                .left_key  ((gi == 0) ? '0 : key_w[(gi == 0) ? 0 : gi - 1]),
                .left_row  ((gi == 0) ? '0 : row_w[(gi == 0) ? 0 : gi - 1]),
                .right_key ((gi == NODES - 1) ? '0 :
                            key_w[(gi == NODES - 1) ? gi : gi + 1]),
                .right_row ((gi == NODES - 1) ? '0 :
                            row_w[(gi == NODES - 1) ? gi : gi + 1]),
                .key       (key_w[gi]),
                .row       (row_w[gi]),
                .eq_a      (eq_a[gi]),
                .lt_a      (lt_a[gi]),
                .eq_b      (eq_b[gi]),
                .lt_b      (lt_b[gi])
            );
            assign occ[gi] = (CNT_W'(gi) < count_reg);
        end
    endgenerate

    // one binary search step; midpoint (lo+hi-1)/2 with hi exclusive
    function automatic srch_t srch_step(srch_t s, logic [NODES-1:0] eq,
                                        logic [NODES-1:0] lt);
        srch_t            r;
        logic [CNT_W:0]   sum;
        logic [IDX_W-1:0] mid;
        r   = s;
        sum = {1'b0, s.lo} + {1'b0, s.hi} - (CNT_W+1)'(1);
        mid = sum[IDX_W:1];
        if (!s.fnd && (s.lo < s.hi))
        begin
            if (eq[mid])
            begin
                r.fnd = 1'b1;
                r.idx = mid;
            end
            else if (lt[mid])
                r.hi = {1'b0, mid};
            else
                r.lo = {1'b0, mid} + CNT_W'(1);
        end
        return r;
    endfunction

    // insertion point: first occupied slot whose key is above the new key
    always_comb
    begin
        ins_pos = count_reg[IDX_W-1:0];
        pos_hit = 1'b0;
        for (int i = 0; i < NODES; i++)
        begin
            if (!pos_hit && occ[i] && lt_a[i])
            begin
                ins_pos = IDX_W'(i);
                pos_hit = 1'b1;
            end
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next   = state_reg;
        sa_next      = sa_reg;
        sb_next      = sb_reg;
        count_next   = count_reg;
        res_st_next  = res_st_reg;
        res_key_next = res_key_reg;
        res_row_next = res_row_reg;
        cmd          = '{op: OP_HOLD, pos: '0, col: '0};
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    sa_next    = '{lo: '0, hi: count_reg, fnd: 1'b0, idx: '0};
                    sb_next    = sa_next;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                sa_next = srch_step(sa_reg, eq_a, lt_a);
                sb_next = srch_step(sb_reg, eq_b, lt_b);
                if ((sa_reg.fnd || sa_reg.lo >= sa_reg.hi) &&
                    (sb_reg.fnd || sb_reg.lo >= sb_reg.hi))
                    state_next = S_APPLY;
            end
            S_APPLY:
            begin
                res_st_next  = ST_OK;
                res_key_next = '0;
                res_row_next = '0;
                case (func_reg)
                    FN_ADD_NODE:
                    begin
                        if (count_reg == CNT_W'(NODES))
                            res_st_next = ST_FULL;
                        else
                        begin
                            cmd        = '{op: OP_INS, pos: ins_pos, col: '0};
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    FN_DEL_NODE:
                    begin
                        if (count_reg == '0)
                            res_st_next = ST_EMPTY;
                        else if (!sa_reg.fnd)
                            res_st_next = ST_NOKEY;
                        else
                        begin
                            cmd        = '{op: OP_DEL, pos: sa_reg.idx, col: '0};
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    FN_ADD_EDGE, FN_DEL_EDGE:
                    begin
                        if (count_reg == '0)
                            res_st_next = ST_EMPTY;
                        else if (!sa_reg.fnd || !sb_reg.fnd)
                            res_st_next = ST_NOKEY;
                        else if (func_reg == FN_ADD_EDGE)
                        begin
                            if (row_w[sa_reg.idx][sb_reg.idx])
                                res_st_next = ST_EXISTS;
                            else
                                cmd = '{op: OP_SET, pos: sa_reg.idx, col: sb_reg.idx};
                        end
                        else
                        begin
                            if (!row_w[sa_reg.idx][sb_reg.idx])
                                res_st_next = ST_ABSENT;
                            else
                                cmd = '{op: OP_CLR, pos: sa_reg.idx, col: sb_reg.idx};
                        end
                    end
                    FN_READ:
                    begin
                        if ({1'b0, slot_reg} < count_reg)
                        begin
                            res_key_next = key_w[slot_reg];
                            res_row_next = row_w[slot_reg];
                        end
                        else
                            res_st_next = ST_UNUSED;
                    end
                    default: ;
                endcase
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            func_reg <= func;
            ka_reg   <= key_a;
            kb_reg   <= key_b;
            slot_reg <= slot_index;
        end
        sa_reg      <= sa_next;
        sb_reg      <= sb_next;
        res_st_reg  <= res_st_next;
        res_key_reg <= res_key_next;
        res_row_reg <= res_row_next;
        if (out_load)
        begin
            status_reg     <= res_st_reg;
            node_count_reg <= count_reg;
            read_key_reg   <= res_key_reg;
            read_row_reg   <= res_row_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign node_count = node_count_reg;
    assign read_key   = read_key_reg;
    assign read_row   = read_row_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(NODES))
        else $error("node count above capacity");

    a_apply_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_APPLY |=> state_reg == S_OUT)
        else $error("update cycle not followed by result stage");

    a_accept_search: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg == S_SEARCH)
        else $error("accepted transfer did not start a search");

    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_APPLY |=> $stable(count_reg))
        else $error("node count changed outside update cycle");
endmodule
`default_nettype wire

[hdl/skam_cell.sv]
// One slot of the graph: key and outgoing-edge row, shifted with neighbors.
// Depends on skam_pkg.
`default_nettype none
module skam_cell (
    input  wire                         clk,
    input  wire                         rst_n,
    input  skam_pkg::cell_cmd_t         cmd,
    input  wire [skam_pkg::IDX_W-1:0]   idx,
    input  wire [skam_pkg::KEY_W-1:0]   key_a,
    input  wire [skam_pkg::KEY_W-1:0]   key_b,
    input  wire [skam_pkg::KEY_W-1:0]   left_key,
    input  wire [skam_pkg::NODES-1:0]   left_row,
    input  wire [skam_pkg::KEY_W-1:0]   right_key,
    input  wire [skam_pkg::NODES-1:0]   right_row,
    output logic [skam_pkg::KEY_W-1:0]  key,
    output logic [skam_pkg::NODES-1:0]  row,
    output logic                        eq_a,
    output logic                        lt_a,
    output logic                        eq_b,
    output logic                        lt_b
);
    import skam_pkg::*;

    logic [KEY_W-1:0] key_reg, key_next;
    logic [NODES-1:0] row_reg, row_next;
    logic [NODES-1:0] row_src;
    logic [NODES-1:0] m;

    assign m = (NODES'(1) << cmd.pos) - NODES'(1);

    always_comb
    begin
        key_next = key_reg;
        row_src  = row_reg;
        row_next = row_reg;
        case (cmd.op)
            OP_INS:
            begin
                if (idx > cmd.pos)
                begin
                    key_next = left_key;
                    row_src  = left_row;
                end
                else if (idx == cmd.pos)
                begin
                    key_next = key_a;
                    row_src  = '0;
                end
                row_next = (row_src & m) | ((row_src & ~m) << 1);
            end
            OP_DEL:
            begin
                if (idx >= cmd.pos)
                begin
                    key_next = right_key;
                    row_src  = right_row;
                end
                row_next = (row_src & m) | ((row_src >> 1) & ~m);
            end
            OP_SET:
            begin
                if (idx == cmd.pos)
                    row_next = row_reg | (NODES'(1) << cmd.col);
            end
            OP_CLR:
            begin
                if (idx == cmd.pos)
                    row_next = row_reg & ~(NODES'(1) << cmd.col);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_reg <= '0;
        else
            row_reg <= row_next;
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key  = key_reg;
    assign row  = row_reg;
    assign eq_a = (key_a == key_reg);
    assign lt_a = (key_a < key_reg);
    assign eq_b = (key_b == key_reg);
    assign lt_b = (key_b < key_reg);
endmodule
`default_nettype wire

[verif/graph_checker.sv]
// Checker for sorted_key_adjacency_matrix: watches both channels, keeps its own
// copy of the sorted key list and edge matrix, and compares every result.
// Depends on skam_pkg.
module graph_checker
    import skam_pkg::*;
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    input  wire                 in_ready,
    input  wire [2:0]           func,
    input  wire [KEY_W-1:0]     key_a,
    input  wire [KEY_W-1:0]     key_b,
    input  wire [IDX_W-1:0]     slot_index,
    input  wire                 out_valid,
    input  wire                 out_ready,
    input  wire [2:0]           status,
    input  wire [CNT_W-1:0]     node_count,
    input  wire [KEY_W-1:0]     read_key,
    input  wire [NODES-1:0]     read_row,
    output int                  fail_count,
    output int                  pending,
    output int                  results_seen
);
    typedef struct packed {
        logic [2:0]       st;
        logic [CNT_W-1:0] cnt;
        logic [KEY_W-1:0] rkey;
        logic [NODES-1:0] rrow;
    } graph_result_t;

    logic [KEY_W-1:0] keys [NODES];
    logic [NODES-1:0] rows [NODES];
    int               nodes;
    graph_result_t    awaited [$];

    assign pending = awaited.size();

    // binary search with the (lo+hi)/2 midpoint, first hit wins
    function automatic int find_key(input logic [KEY_W-1:0] k);
        int lo, hi, mid;
        lo = 0;
        hi = nodes - 1;
        while (lo <= hi)
        begin
            mid = (lo + hi) / 2;
            if (k == keys[mid])
                return mid;
            if (k < keys[mid])
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        return -1;
    endfunction

    function automatic graph_result_t apply_item(input logic [2:0] f,
        input logic [KEY_W-1:0] ka, input logic [KEY_W-1:0] kb, input logic [IDX_W-1:0] si);
        graph_result_t res;
        int pos, i, j;
        logic [NODES-1:0] lowm, row;
        res = '0;
        res.st = ST_OK;
        case (f)
            FN_ADD_NODE:
                if (nodes >= NODES)
                    res.st = ST_FULL;
                else
                begin
                    pos = 0;
                    while (pos < nodes && keys[pos] <= ka)
                        pos++;
                    for (int r = nodes; r > pos; r--)
                    begin
                        keys[r] = keys[r-1];
                        rows[r] = rows[r-1];
                    end
                    keys[pos] = ka;
                    rows[pos] = '0;
                    nodes++;
                    lowm = (NODES'(1) << pos) - NODES'(1);
                    for (int r = 0; r < nodes; r++)
                    begin
                        row = rows[r];
                        rows[r] = (row & lowm) | ((row & ~lowm) << 1);
                    end
                end
            FN_DEL_NODE:
                if (nodes == 0)
                    res.st = ST_EMPTY;
                else
                begin
                    i = find_key(ka);
                    if (i < 0)
                        res.st = ST_NOKEY;
                    else
                    begin
                        for (int r = i; r + 1 < nodes; r++)
                        begin
                            keys[r] = keys[r+1];
                            rows[r] = rows[r+1];
                        end
                        nodes--;
                        keys[nodes] = '0;
                        rows[nodes] = '0;
                        lowm = (NODES'(1) << i) - NODES'(1);
                        for (int r = 0; r < nodes; r++)
                        begin
                            row = rows[r];
                            rows[r] = (row & lowm) | ((row >> (i + 1)) << i);
                        end
                    end
                end
            FN_ADD_EDGE, FN_DEL_EDGE:
                if (nodes == 0)
                    res.st = ST_EMPTY;
                else
                begin
                    i = find_key(ka);
                    j = find_key(kb);
                    if (i < 0 || j < 0)
                        res.st = ST_NOKEY;
                    else if (f == FN_ADD_EDGE)
                    begin
                        if (rows[i][j])
                            res.st = ST_EXISTS;
                        else
                            rows[i][j] = 1'b1;
                    end
                    else
                    begin
                        if (!rows[i][j])
                            res.st = ST_ABSENT;
                        else
                            rows[i][j] = 1'b0;
                    end
                end
            FN_READ:
                if (si < nodes)
                begin
                    res.rkey = keys[si];
                    res.rrow = rows[si];
                end
                else
                    res.st = ST_UNUSED;
            default: ;
        endcase
        res.cnt = CNT_W'(nodes);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        graph_result_t exp_r, got;
        if (!rst_n)
        begin
            for (int r = 0; r < NODES; r++)
            begin
                keys[r] = '0;
                rows[r] = '0;
            end
            nodes = 0;
            awaited.delete();
            fail_count = 0;
            results_seen = 0;
        end
        else
        begin
            // result first: the transfer out cannot be the one just accepted
            if (out_valid && out_ready)
            begin
                results_seen++;
                got = '{status, node_count, read_key, read_row};
                if (awaited.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result st=%0d cnt=%0d key=%h row=%h",
                             $time, status, node_count, read_key, read_row);
                end
                else
                begin
                    exp_r = awaited.pop_front();
                    if (got.st !== exp_r.st)
                    begin
                        fail_count++;
                        $display("%0t: status expected %0d got %0d", $time, exp_r.st, got.st);
                    end
                    if (got.cnt !== exp_r.cnt)
                    begin
                        fail_count++;
                        $display("%0t: node_count expected %0d got %0d",
                                 $time, exp_r.cnt, got.cnt);
                    end
                    if (got.rkey !== exp_r.rkey)
                    begin
                        fail_count++;
                        $display("%0t: read_key expected %h got %h",
                                 $time, exp_r.rkey, got.rkey);
                    end
                    if (got.rrow !== exp_r.rrow)
                    begin
                        fail_count++;
                        $display("%0t: read_row expected %h got %h",
                                 $time, exp_r.rrow, got.rrow);
                    end
                end
            end
            if (in_valid && in_ready)
                awaited.push_back(apply_item(func, key_a, key_b, slot_index));
        end
    end
endmodule

[verif/tb.sv]
// Top of the sorted_key_adjacency_matrix testbench: clock, reset, stimulus
// and verdict. Depends on skam_pkg, graph_checker and the block itself.
module tb;
    import skam_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [2:0]       func;
    logic [KEY_W-1:0] key_a;
    logic [KEY_W-1:0] key_b;
    logic [IDX_W-1:0] slot_index;
    logic             out_valid;
    logic             out_ready;
    logic [2:0]       status;
    logic [CNT_W-1:0] node_count;
    logic [KEY_W-1:0] read_key;
    logic [NODES-1:0] read_row;
    int               fail_count;
    int               pending;
    int               results_seen;
    int               cycles;
    bit               calm;       // no idling in the last part
    bit               hold_off;   // long receiver stall request
    logic [KEY_W-1:0] pool [8];   // small key pool so searches hit often

    sorted_key_adjacency_matrix dut (.*);
    graph_checker chk (.*);

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        int n;
        bit held;
        held = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off && !held)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (80) @(negedge clk);
                out_ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                n = $urandom_range(1, 10);
                repeat (n - 1) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // one transfer; driven at the falling edge, held until accepted
    task automatic send(input logic [2:0] f, input logic [KEY_W-1:0] ka,
                        input logic [KEY_W-1:0] kb, input logic [IDX_W-1:0] si);
        int n;
        if (!calm && $urandom_range(0, 6) == 0)
        begin
            in_valid <= 1'b0;
            n = $urandom_range(1, 10);
            repeat (n) @(negedge clk);
        end
        in_valid   <= 1'b1;
        func       <= f;
        key_a      <= ka;
        key_b      <= kb;
        slot_index <= si;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 9) == 0)
            return KEY_W'($urandom);
        return pool[$urandom_range(0, 7)];
    endfunction

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            send(FN_ADD_NODE, pick_key(), KEY_W'($urandom), IDX_W'($urandom));
        else if (r < 45)
            send(FN_DEL_NODE, pick_key(), KEY_W'($urandom), IDX_W'($urandom));
        else if (r < 65)
            send(FN_ADD_EDGE, pick_key(), pick_key(), IDX_W'($urandom));
        else if (r < 75)
            send(FN_DEL_EDGE, pick_key(), pick_key(), IDX_W'($urandom));
        else if (r < 97)
            send(FN_READ, KEY_W'($urandom), KEY_W'($urandom), IDX_W'($urandom));
        else
            send(3'($urandom_range(5, 7)), KEY_W'($urandom), KEY_W'($urandom),
                 IDX_W'($urandom));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        func       = '0;
        key_a      = '0;
        key_b      = '0;
        slot_index = '0;
        calm       = 1'b0;
        hold_off   = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty graph cases, extremes, duplicates, full
        send(FN_DEL_NODE, 16'h1234, '0, '0);
        send(FN_ADD_EDGE, 16'h0000, 16'h0000, '0);
        send(FN_DEL_EDGE, 16'hffff, 16'hffff, '0);
        send(FN_READ, '0, '0, 4'd0);
        send(FN_ADD_NODE, 16'hffff, '0, '0);
        send(FN_ADD_NODE, 16'h0000, '0, '0);
        send(FN_ADD_NODE, 16'h8000, '0, '0);
        send(FN_ADD_EDGE, 16'hffff, 16'h0000, '0);
        send(FN_ADD_EDGE, 16'hffff, 16'h0000, '0);
        send(FN_ADD_EDGE, 16'h0000, 16'h0000, '0);
        send(FN_ADD_NODE, 16'h8000, '0, '0);
        send(FN_ADD_EDGE, 16'h8000, 16'hffff, '0);
        send(FN_DEL_EDGE, 16'h0000, 16'h8000, '0);
        send(FN_READ, '0, '0, 4'd3);
        send(FN_DEL_NODE, 16'h8000, '0, '0);
        send(FN_DEL_NODE, 16'h7777, '0, '0);
        send(FN_DEL_EDGE, 16'h0000, 16'h0000, '0);
        send(3'd7, 16'hffff, 16'hffff, 4'hf);
        for (int k = 0; k < 14; k++)
            send(FN_ADD_NODE, KEY_W'(k * 4681), '0, '0);
        send(FN_ADD_NODE, 16'h5555, '0, '0);   // full
        send(FN_READ, '0, '0, 4'd15);
        send(FN_READ, '0, '0, 4'd0);
        for (int k = 0; k < 16; k++)
            send(FN_DEL_NODE, KEY_W'(k * 4681), '0, '0);
        drain();

        // pause until quiet, then stall the receiver while offering items
        for (int k = 0; k < 8; k++)
            pool[k] = ($urandom_range(0, 1) != 0) ? KEY_W'($urandom) : KEY_W'(k * 9362);
        hold_off = 1'b1;
        for (int k = 0; k < 12; k++)
            random_item();
        drain();

        for (int k = 0; k < 1600; k++)
        begin
            if (k % 300 == 0)
                for (int p = 0; p < 8; p++)
                    pool[p] = KEY_W'($urandom);
            if (k == 1300)
                calm = 1'b1;
            random_item();
        end
        drain();
        repeat (20) @(negedge clk);

        $display("%0d results checked: node insert/remove with duplicates and full graph,",
                 results_seen);
        $display("edge set/clear, slot reads, unused codes, with stalls on both sides");
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
